// ===== rtl/core/rnpr_pkg.sv =====
// shared types and constants for the next-pc resolver
`timescale 1ns / 1ps

package rnpr_pkg;

    localparam int unsigned XLEN      = 64;
    localparam int unsigned NUM_REGS  = 32;
    localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_4    = 3'd4;

    typedef enum logic [2:0] {
        STOP_NONE       = 3'd0,
        STOP_UNREADABLE = 3'd1,
        STOP_C_EBREAK   = 3'd2,
        STOP_EBREAK     = 3'd3,
        STOP_SRET       = 3'd4
    } stop_reason_t;

    typedef struct packed {
        logic [XLEN-1:0] pc;
        logic [15:0]     low_half;
        logic [15:0]     high_half;
        logic            low_readable;
        logic            high_readable;
    } step_t;

    typedef struct packed {
        logic [XLEN-1:0] next_pc;
        logic            steppable;
        stop_reason_t    stop_reason;
        logic [2:0]      instruction_length;
    } result_t;

endpackage

// ===== rtl/core/rnpr_req_if.sv =====
// request channel of the next-pc resolver
`timescale 1ns / 1ps

interface rnpr_req_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [rnpr_pkg::REG_IDX_W-1:0]      reg_index;
    logic [rnpr_pkg::XLEN-1:0]           reg_value;
    logic [rnpr_pkg::XLEN-1:0]           pc;
    logic [15:0]                         low_half;
    logic [15:0]                         high_half;
    logic                                low_readable;
    logic                                high_readable;

    modport source (
        output valid, kind, reg_index, reg_value, pc, low_half, high_half,
               low_readable, high_readable,
        input  ready
    );

    modport sink (
        input  valid, kind, reg_index, reg_value, pc, low_half, high_half,
               low_readable, high_readable,
        output ready
    );
endinterface

// ===== rtl/core/rnpr_rsp_if.sv =====
// result channel of the next-pc resolver
`timescale 1ns / 1ps

interface rnpr_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [rnpr_pkg::XLEN-1:0]  next_pc;
    logic                       steppable;
    rnpr_pkg::stop_reason_t     stop_reason;
    logic [2:0]                 instruction_length;

    modport source (
        output valid, next_pc, steppable, stop_reason, instruction_length,
        input  ready
    );

    modport sink (
        input  valid, next_pc, steppable, stop_reason, instruction_length,
        output ready
    );
endinterface

// ===== rtl/core/rnpr_ram.sv =====
// generic ram, one write port, two registered read ports
`timescale 1ns / 1ps

module rnpr_ram #(
    parameter int unsigned WIDTH = rnpr_pkg::XLEN,
    parameter int unsigned DEPTH = rnpr_pkg::NUM_REGS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/core/rnpr_resolve.sv =====
// instruction length and successor pc decode for rv64c
`timescale 1ns / 1ps

module rnpr_resolve (
    input  rnpr_pkg::step_t                step,
    input  logic [rnpr_pkg::XLEN-1:0]      rs1_value,
    input  logic [rnpr_pkg::XLEN-1:0]      rs2_value,
    output rnpr_pkg::result_t              result
);

    localparam logic [1:0] QUAD_0    = 2'b00;
    localparam logic [1:0] QUAD_1    = 2'b01;
    localparam logic [1:0] QUAD_2    = 2'b10;
    localparam logic [1:0] QUAD_LONG = 2'b11;

    localparam logic [2:0] CF3_JR   = 3'd4;
    localparam logic [2:0] CF3_J    = 3'd5;
    localparam logic [2:0] CF3_BEQZ = 3'd6;
    localparam logic [2:0] CF3_BNEZ = 3'd7;

    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
    localparam logic [31:0] WORD_SRET   = 32'h1020_0073;

    localparam logic [2:0] BR_EQ  = 3'd0;
    localparam logic [2:0] BR_NE  = 3'd1;
    localparam logic [2:0] BR_LT  = 3'd4;
    localparam logic [2:0] BR_GE  = 3'd5;
    localparam logic [2:0] BR_LTU = 3'd6;
    localparam logic [2:0] BR_GEU = 3'd7;

    localparam int unsigned XL = rnpr_pkg::XLEN;

    logic [15:0]    low;
    logic [31:0]    word;
    logic [1:0]     quad;
    logic [2:0]     c_f3;
    logic [XL-1:0]  off_cj;
    logic [XL-1:0]  off_cb;
    logic [XL-1:0]  off_jal;
    logic [XL-1:0]  off_br;
    logic [XL-1:0]  imm_i;
    logic [XL-1:0]  target_off;
    logic [XL-1:0]  target_pc;
    logic [XL-1:0]  seq_pc;
    logic [XL-1:0]  jalr_pc;
    logic [XL-1:0]  cjr_pc;
    logic           taken;
    logic           rs1_zero;

    assign low  = step.low_half;
    assign word = {step.high_half, step.low_half};
    assign quad = low[1:0];
    assign c_f3 = low[15:13];

    assign off_cj  = {{(XL-12){low[12]}}, low[12], low[8], low[10:9], low[6], low[7],
                      low[2], low[11], low[5:3], 1'b0};
    assign off_cb  = {{(XL-9){low[12]}}, low[12], low[6:5], low[2], low[11:10],
                      low[4:3], 1'b0};
    assign off_jal = {{(XL-21){word[31]}}, word[31], word[19:12], word[20],
                      word[30:21], 1'b0};
    assign off_br  = {{(XL-13){word[31]}}, word[31], word[7], word[30:25],
                      word[11:8], 1'b0};
    assign imm_i   = {{(XL-12){word[31]}}, word[31:20]};

    assign rs1_zero = (rs1_value == '0);

    always_comb
    begin
        case (word[14:12])
            BR_EQ:   taken = (rs1_value == rs2_value);
            BR_NE:   taken = (rs1_value != rs2_value);
            BR_LT:   taken = ($signed(rs1_value) <  $signed(rs2_value));
            BR_GE:   taken = ($signed(rs1_value) >= $signed(rs2_value));
            BR_LTU:  taken = (rs1_value <  rs2_value);
            BR_GEU:  taken = (rs1_value >= rs2_value);
            default: taken = 1'b0;
        endcase
    end

    // one shared adder for all pc-relative targets
    always_comb
    begin
        if (quad != QUAD_LONG)
        begin
            target_off = (c_f3 == CF3_J) ? off_cj : off_cb;
        end
        else
        begin
            target_off = (word[6:0] == OPC_JAL) ? off_jal : off_br;
        end
    end

    assign target_pc = step.pc + target_off;
    assign seq_pc    = step.pc + ((quad == QUAD_LONG) ? XL'(4) : XL'(2));
    assign jalr_pc   = (rs1_value + imm_i) & ~XL'(1);
    assign cjr_pc    = rs1_value & ~XL'(1);

    always_comb
    begin
        result.next_pc            = seq_pc;
        result.stop_reason        = rnpr_pkg::STOP_NONE;
        result.instruction_length = (quad == QUAD_LONG) ? rnpr_pkg::LEN_4 : rnpr_pkg::LEN_2;

        if (!step.low_readable || (quad == QUAD_LONG && !step.high_readable))
        begin
            result.next_pc            = '0;
            result.stop_reason        = rnpr_pkg::STOP_UNREADABLE;
            result.instruction_length = rnpr_pkg::LEN_NONE;
        end
        else
        begin
            unique case (quad)
                QUAD_1:
                begin
                    if (c_f3 == CF3_J
                        || (c_f3 == CF3_BEQZ && rs1_zero)
                        || (c_f3 == CF3_BNEZ && !rs1_zero))
                    begin
                        result.next_pc = target_pc;
                    end
                end
                QUAD_2:
                begin
                    if (c_f3 == CF3_JR && low[6:2] == 5'd0)
                    begin
                        // jump through x0 is c.ebreak
                        if (low[11:7] == 5'd0)
                        begin
                            result.stop_reason = rnpr_pkg::STOP_C_EBREAK;
                        end
                        else
                        begin
                            result.next_pc = cjr_pc;
                        end
                    end
                end
                QUAD_LONG:
                begin
                    unique case (word[6:0])
                        OPC_JAL:    result.next_pc = target_pc;
                        OPC_JALR:   result.next_pc = jalr_pc;
                        OPC_BRANCH:
                        begin
                            if (taken)
                            begin
                                result.next_pc = target_pc;
                            end
                        end
                        OPC_SYSTEM:
                        begin
                            if (word == WORD_EBREAK)
                            begin
                                result.stop_reason = rnpr_pkg::STOP_EBREAK;
                            end
                            else if (word == WORD_SRET)
                            begin
                                result.stop_reason = rnpr_pkg::STOP_SRET;
                            end
                        end
                        default: ;
                    endcase
                end
                QUAD_0: ;
                default: ;
            endcase
        end

        result.steppable = (result.stop_reason == rnpr_pkg::STOP_NONE);
    end

endmodule

// ===== rtl/core/riscv_next_pc_resolver_top.sv =====
// next-pc resolver for rv64c single-step: register file, read stage and result register
//
// Requests of kind write load one of 32 64-bit integer registers (x0 stays zero) and give
// no result; requests of kind step give exactly one result. One request is taken every
// cycle unless a full pipeline stalls on the result ready; a step result passes first
// through the registered read of the register file ram (two read ports, for rs1 and
// rs2), then through the length and target decode, with one adder shared by the
// pc-relative targets, into the result register. Registers not yet written since reset
// read as zero through per-entry valid flops, so no clearing pass is needed. When the
// read stage and the result register both hold a step, the request ready follows the
// result ready in the same cycle.
`timescale 1ns / 1ps

module riscv_next_pc_resolver_top (
    input  logic              clk,
    input  logic              rst_n,
    rnpr_req_if.sink          req,
    rnpr_rsp_if.source        rsp
);

    localparam int unsigned XL = rnpr_pkg::XLEN;
    localparam int unsigned NR = rnpr_pkg::NUM_REGS;
    localparam int unsigned AW = rnpr_pkg::REG_IDX_W;

    logic                   accept;
    logic                   s1_advance;
    logic                   wr_en;
    logic                   rd_en;
    logic [AW-1:0]          rs1_addr;
    logic [AW-1:0]          rs2_addr;
    logic [XL-1:0]          rs1_raw;
    logic [XL-1:0]          rs2_raw;
    logic [XL-1:0]          rs1_value;
    logic [XL-1:0]          rs2_value;

    logic [NR-1:0]          reg_valid_reg;
    logic [NR-1:0]          reg_valid_next;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    logic                   rs1_ok_reg;
    logic                   rs2_ok_reg;
    rnpr_pkg::step_t        s1_step_reg;
    rnpr_pkg::result_t      result;
    rnpr_pkg::result_t      rsp_data_reg;

    assign s1_advance = !rsp_valid_reg || rsp.ready;
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign accept     = req.valid && req.ready;
    assign wr_en      = accept && req.kind == rnpr_pkg::KIND_WRITE && req.reg_index != '0;
    assign rd_en      = accept && req.kind == rnpr_pkg::KIND_STEP;

    // source registers: quadrant 1 uses the short x8..x15 field
    always_comb
    begin
        rs2_addr = req.high_half[8:4];
        if (req.low_half[1:0] == 2'b11)
        begin
            rs1_addr = req.low_half[15]
                ? {req.high_half[3:0], 1'b1} : {req.high_half[3:0], 1'b0};
        end
        else if (req.low_half[1:0] == 2'b01)
        begin
            rs1_addr = {2'b01, req.low_half[9:7]};
        end
        else
        begin
            rs1_addr = req.low_half[11:7];
        end
    end

    rnpr_ram #(
        .WIDTH (XL),
        .DEPTH (NR)
    ) u_regfile (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (req.reg_index),
        .wdata   (req.reg_value),
        .re      (rd_en),
        .raddr_a (rs1_addr),
        .raddr_b (rs2_addr),
        .rdata_a (rs1_raw),
        .rdata_b (rs2_raw)
    );

    assign rs1_value = rs1_ok_reg ? rs1_raw : '0;
    assign rs2_value = rs2_ok_reg ? rs2_raw : '0;

    rnpr_resolve u_resolve (
        .step      (s1_step_reg),
        .rs1_value (rs1_value),
        .rs2_value (rs2_value),
        .result    (result)
    );

    always_comb
    begin
        reg_valid_next = reg_valid_reg;
        if (wr_en)
        begin
            reg_valid_next[req.reg_index] = 1'b1;
        end

        if (accept)
        begin
            s1_valid_next = rd_en;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        rsp_valid_next = s1_advance ? s1_valid_reg : rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            reg_valid_reg <= reg_valid_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_step_reg.pc            <= req.pc;
            s1_step_reg.low_half      <= req.low_half;
            s1_step_reg.high_half     <= req.high_half;
            s1_step_reg.low_readable  <= req.low_readable;
            s1_step_reg.high_readable <= req.high_readable;
            rs1_ok_reg                <= reg_valid_reg[rs1_addr];
            rs2_ok_reg                <= reg_valid_reg[rs2_addr];
        end
        if (s1_valid_reg && s1_advance)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp.valid              = rsp_valid_reg;
    assign rsp.next_pc            = rsp_data_reg.next_pc;
    assign rsp.steppable          = rsp_data_reg.steppable;
    assign rsp.stop_reason        = rsp_data_reg.stop_reason;
    assign rsp.instruction_length = rsp_data_reg.instruction_length;

endmodule
